/* sv/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg: shared constants for the point-to-segment distance block
// Holds the parameter fraction width.
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int TPAR_BITS = 24;
endpackage

/* sv/psd_if.sv */
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if: valid/ready channels of the distance block
// One transaction moves one query or one result.
// ----------------------------------------------------------------------------
interface psd_in_if #(parameter int CB = 24);
  logic valid;
  logic ready;
  logic signed [CB-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic signed [CB-1:0] point_x, point_y;
  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  point_x, point_y, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                point_x, point_y, output ready);
endinterface

interface psd_out_if #(parameter int CB = 24);
  logic valid;
  logic ready;
  logic [CB:0] distance;
  logic degenerate;
  modport source (output valid, distance, degenerate, input ready);
  modport sink (input valid, distance, degenerate, output ready);
endinterface

/* sv/psd_div_cell.sv */
// ----------------------------------------------------------------------------
// psd_div_cell: one restoring-division step for the segment parameter
// Shifts the remainder, subtracts len2 when it fits, appends a quotient bit.
// ----------------------------------------------------------------------------
module psd_div_cell #(parameter int W = 50, parameter int CB = 24) (
  input  logic clk,
  input  logic en,
  input  logic [W-1:0] r_in, len2_in,
  input  logic [psd_pkg::TPAR_BITS-1:0] t_in,
  input  logic signed [CB:0] ax_in, ay_in, lx_in, ly_in,
  input  logic signed [CB:0] fx_in, fy_in,
  input  logic [1:0] sel_in,
  input  logic deg_in,
  output logic [W-1:0] r_r, len2_r,
  output logic [psd_pkg::TPAR_BITS-1:0] t_r,
  output logic signed [CB:0] ax_r, ay_r, lx_r, ly_r, fx_r, fy_r,
  output logic [1:0] sel_r,
  output logic deg_r
);
  logic [W:0] sh;
  logic ge;
  assign sh = {r_in, 1'b0};
  assign ge = sh >= {1'b0, len2_in};
  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= ge ? W'(sh - {1'b0, len2_in}) : W'(sh);
      t_r <= {t_in[psd_pkg::TPAR_BITS-2:0], ge};
      len2_r <= len2_in;
      ax_r <= ax_in; ay_r <= ay_in; lx_r <= lx_in; ly_r <= ly_in;
      fx_r <= fx_in; fy_r <= fy_in; sel_r <= sel_in; deg_r <= deg_in;
    end
  end
endmodule

/* sv/psd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// psd_sqrt_cell: one non-restoring-free bit step of the integer square root
// Tries the next result bit and keeps it when its square still fits.
// ----------------------------------------------------------------------------
module psd_sqrt_cell #(parameter int W = 50, parameter int RW = 25, parameter int BIT = 0,
                       parameter int CB = 24) (
  input  logic clk,
  input  logic en,
  input  logic [W-1:0] n_in,
  input  logic [W-1:0] rem_in,
  input  logic [RW-1:0] q_in,
  input  logic deg_in,
  output logic [W-1:0] n_r,
  output logic [W-1:0] rem_r,
  output logic [RW-1:0] q_r,
  output logic deg_r
);
  // rem = n - q^2 ; trying q+2^b costs 2*q*2^b + 2^(2b)
  logic [W+1:0] cost;
  assign cost = ({{(W+2-RW){1'b0}}, q_in} << (BIT + 1)) + ((W+2)'(1) << (2 * BIT));
  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_in;
      deg_r <= deg_in;
      if (cost <= {2'b00, rem_in}) begin
        rem_r <= W'({2'b00, rem_in} - cost);
        q_r <= q_in | (RW'(1) << BIT);
      end else begin
        rem_r <= rem_in;
        q_r <= q_in;
      end
    end
  end
endmodule

/* sv/point_segment_distance.sv */
// ----------------------------------------------------------------------------
// point_segment_distance: distance from a point to a 2-D segment
// Fixed-point projection, clamp, divide and square root in a cell chain.
// ----------------------------------------------------------------------------
// Usage: queries arrive on in_ (valid/ready), one transaction per query with
// the segment start, end and target point. Each result leaves on out_ with
// the distance (COORD_BITS+1 bits, same fixed-point scale as the coordinates,
// floor of the root) and a degenerate flag for a zero-length segment.
// Throughput is one query per cycle while the receiver takes results. The
// chain holds four front stages, one division cell per parameter bit, an
// offset stage with its multiply, a squaring stage, one square-root cell per
// result bit and an output register.
// The whole chain advances together; when the receiver stalls with a result
// waiting, the chain freezes and in_ready drops, so nothing is lost.
// Reset clears the valid bits of all stages; data registers are not reset.
// ----------------------------------------------------------------------------
module point_segment_distance #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  psd_in_if.sink in_ch,
  psd_out_if.source out_ch
);
  localparam int CB = COORD_BITS;
  localparam int TB = psd_pkg::TPAR_BITS;
  localparam int D = CB + 1;
  localparam int W = 2 * D;
  localparam int NDIV = TB;
  localparam int NSQ = D;
  localparam int NV = 7 + NDIV + NSQ;
  localparam int FRAC_UNUSED = FRAC_BITS;

  logic [NV-1:0] vld_r;
  logic en;
  assign en = !vld_r[NV-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NV-2:0], in_ch.valid};
  end

  // stage 1: differences
  logic signed [D-1:0] lx1_r, ly1_r, ax1_r, ay1_r, fx1_r, fy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      lx1_r <= D'(in_ch.seg_end_x) - D'(in_ch.seg_start_x);
      ly1_r <= D'(in_ch.seg_end_y) - D'(in_ch.seg_start_y);
      ax1_r <= D'(in_ch.point_x) - D'(in_ch.seg_start_x);
      ay1_r <= D'(in_ch.point_y) - D'(in_ch.seg_start_y);
      fx1_r <= D'(in_ch.point_x) - D'(in_ch.seg_end_x);
      fy1_r <= D'(in_ch.point_y) - D'(in_ch.seg_end_y);
    end
  end
  // sign-extend helper width D -> 1.. done with $signed
  // stage 2: products
  logic signed [W-1:0] pxx2_r, pyy2_r, lxx2_r, lyy2_r;
  logic signed [D-1:0] lx2_r, ly2_r, ax2_r, ay2_r, fx2_r, fy2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pxx2_r <= W'(ax1_r * lx1_r);
      pyy2_r <= W'(ay1_r * ly1_r);
      lxx2_r <= W'(lx1_r * lx1_r);
      lyy2_r <= W'(ly1_r * ly1_r);
      lx2_r <= lx1_r; ly2_r <= ly1_r; ax2_r <= ax1_r; ay2_r <= ay1_r;
      fx2_r <= fx1_r; fy2_r <= fy1_r;
    end
  end
  // stage 3: dot and len2
  logic signed [W:0] dot3_r;
  logic [W-1:0] len3_r;
  logic signed [D-1:0] lx3_r, ly3_r, ax3_r, ay3_r, fx3_r, fy3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dot3_r <= (W+1)'(pxx2_r) + (W+1)'(pyy2_r);
      len3_r <= W'(lxx2_r) + W'(lyy2_r);
      lx3_r <= lx2_r; ly3_r <= ly2_r; ax3_r <= ax2_r; ay3_r <= ay2_r;
      fx3_r <= fx2_r; fy3_r <= fy2_r;
    end
  end
  // stage 4: clamp decision; sel 0 = start, 1 = end, 2 = interior
  logic [1:0] sel4_r;
  logic [W-1:0] r4_r, len4_r;
  logic deg4_r;
  logic signed [D-1:0] lx4_r, ly4_r, ax4_r, ay4_r, fx4_r, fy4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (dot3_r <= 0) sel4_r <= 2'd0;
      else if (dot3_r >= $signed({1'b0, len3_r})) sel4_r <= 2'd1;
      else sel4_r <= 2'd2;
      r4_r <= W'(dot3_r);
      len4_r <= len3_r;
      deg4_r <= len3_r == '0;
      lx4_r <= lx3_r; ly4_r <= ly3_r; ax4_r <= ax3_r; ay4_r <= ay3_r;
      fx4_r <= fx3_r; fy4_r <= fy3_r;
    end
  end

  // division chain
  logic [W-1:0] dr [NDIV+1];
  logic [W-1:0] dl [NDIV+1];
  logic [TB-1:0] dt [NDIV+1];
  logic signed [D-1:0] dax [NDIV+1], day [NDIV+1], dlx [NDIV+1], dly [NDIV+1];
  logic signed [D-1:0] dfx [NDIV+1], dfy [NDIV+1];
  logic [1:0] dsel [NDIV+1];
  logic ddeg [NDIV+1];
  assign dr[0] = r4_r; assign dl[0] = len4_r; assign dt[0] = '0;
  assign dax[0] = ax4_r; assign day[0] = ay4_r; assign dlx[0] = lx4_r;
  assign dly[0] = ly4_r; assign dfx[0] = fx4_r; assign dfy[0] = fy4_r;
  assign dsel[0] = sel4_r; assign ddeg[0] = deg4_r;
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    psd_div_cell #(.W(W), .CB(CB)) u_cell (
      .clk(clk), .en(en), .r_in(dr[i]), .len2_in(dl[i]), .t_in(dt[i]),
      .ax_in(dax[i]), .ay_in(day[i]), .lx_in(dlx[i]), .ly_in(dly[i]),
      .fx_in(dfx[i]), .fy_in(dfy[i]), .sel_in(dsel[i]), .deg_in(ddeg[i]),
      .r_r(dr[i+1]), .len2_r(dl[i+1]), .t_r(dt[i+1]),
      .ax_r(dax[i+1]), .ay_r(day[i+1]), .lx_r(dlx[i+1]), .ly_r(dly[i+1]),
      .fx_r(dfx[i+1]), .fy_r(dfy[i+1]), .sel_r(dsel[i+1]), .deg_r(ddeg[i+1]));
  end

  // stage 5: offsets |l|*t rounded, applied with sign
  logic [D-1:0] mlx, mly;
  assign mlx = dlx[NDIV][D-1] ? D'(-dlx[NDIV]) : D'(dlx[NDIV]);
  assign mly = dly[NDIV][D-1] ? D'(-dly[NDIV]) : D'(dly[NDIV]);
  logic [D+TB-1:0] ox5_r, oy5_r;
  logic slx5_r, sly5_r, deg5_r;
  logic [1:0] sel5_r;
  logic signed [D-1:0] ax5_r, ay5_r, fx5_r, fy5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ox5_r <= (D+TB)'(mlx) * (D+TB)'(dt[NDIV]);
      oy5_r <= (D+TB)'(mly) * (D+TB)'(dt[NDIV]);
      slx5_r <= dlx[NDIV][D-1]; sly5_r <= dly[NDIV][D-1];
      sel5_r <= dsel[NDIV]; deg5_r <= ddeg[NDIV];
      ax5_r <= dax[NDIV]; ay5_r <= day[NDIV]; fx5_r <= dfx[NDIV]; fy5_r <= dfy[NDIV];
    end
  end
  logic [D+TB-1:0] rx, ry;
  assign rx = ox5_r + ((D+TB)'(1'b1) << (TB - 1));
  assign ry = oy5_r + ((D+TB)'(1'b1) << (TB - 1));
  logic signed [D:0] ofx, ofy, dxv, dyv;
  assign ofx = slx5_r ? -$signed({1'b0, rx[D+TB-1:TB]}) : $signed({1'b0, rx[D+TB-1:TB]});
  assign ofy = sly5_r ? -$signed({1'b0, ry[D+TB-1:TB]}) : $signed({1'b0, ry[D+TB-1:TB]});
  always_comb begin
    unique case (sel5_r)
      2'd0: begin dxv = (D+1)'(ax5_r); dyv = (D+1)'(ay5_r); end
      2'd1: begin dxv = (D+1)'(fx5_r); dyv = (D+1)'(fy5_r); end
      default: begin dxv = (D+1)'(ax5_r) - ofx; dyv = (D+1)'(ay5_r) - ofy; end
    endcase
  end
  // stage 6: squares of the final offsets (magnitude fits D bits)
  logic [D-1:0] mdx, mdy;
  assign mdx = dxv[D] ? D'(-dxv) : D'(dxv);
  assign mdy = dyv[D] ? D'(-dyv) : D'(dyv);
  logic [W-1:0] sx6_r, sy6_r;
  logic deg6_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sx6_r <= W'(mdx) * W'(mdx);
      sy6_r <= W'(mdy) * W'(mdy);
      deg6_r <= deg5_r;
    end
  end
  logic [W-1:0] sq_sum;
  assign sq_sum = sx6_r + sy6_r;

  // square root chain, MSB first
  logic [W-1:0] sn [NSQ+1], srem [NSQ+1];
  logic [D-1:0] sq [NSQ+1];
  logic sdeg [NSQ+1];
  assign sn[0] = sq_sum; assign srem[0] = sq_sum; assign sq[0] = '0;
  assign sdeg[0] = deg6_r;
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    psd_sqrt_cell #(.W(W), .RW(D), .BIT(NSQ - 1 - k), .CB(CB)) u_cell (
      .clk(clk), .en(en), .n_in(sn[k]), .rem_in(srem[k]), .q_in(sq[k]),
      .deg_in(sdeg[k]), .n_r(sn[k+1]), .rem_r(srem[k+1]), .q_r(sq[k+1]),
      .deg_r(sdeg[k+1]));
  end

  logic [D-1:0] dist_r;
  logic deg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= sq[NSQ];
      deg_r <= sdeg[NSQ];
    end
  end
  assign out_ch.valid = vld_r[NV-1];
  assign out_ch.distance = dist_r;
  assign out_ch.degenerate = deg_r;

  logic unused_ok;
  assign unused_ok = ^{sn[NSQ], srem[NSQ], dr[NDIV], dl[NDIV], FRAC_UNUSED[0]};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.distance))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready does not follow chain enable");
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && deg4_r |-> sel4_r == 2'd0)
    else $error("degenerate segment not clamped to start");
endmodule
